// ===== hdl/lbgm_pkg.sv =====
// Shared types and constants of the bar-graph level meter
package lbgm_pkg;

   localparam int OFFSET_W  = 12;
   localparam int SCALE_W   = 23;
   localparam int LEVEL_W   = 15;
   localparam int BAR_N     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SCALE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q16     = 1'b1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd1840;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 23'd15984;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 15'd25600;
   localparam logic [LEVEL_W-1:0] BLINK_BELOW = 15'd1280;
   localparam logic [13:0]        AVG_WEIGHT  = 14'd13107;
   localparam int                 ROUND_HALF  = 32768;

   localparam logic [LEVEL_W-1:0] BAR_LEVEL [BAR_N] =
      '{15'd2560, 15'd5120, 15'd10240, 15'd15360, 15'd20480};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SCALE,
      ST_CLAMP,
      ST_MAG,
      ST_WEIGHT,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take_sample;
      logic calc_diff;
      logic mul_level;
      logic clamp;
      logic calc_mag;
      logic mul_weight;
      logic update;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/lbgm_if.sv =====
// Request and response channel interfaces of the level meter
interface lbgm_req_if #(parameter int SAMPLE_BITS = 12) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface lbgm_rsp_if ();
   logic        valid;
   logic        ready;
   logic [14:0] level_percent;
   logic [14:0] average_percent;
   logic [4:0]  bar_lit;
   logic        status_lit;

   modport source (output valid, output level_percent, output average_percent,
                   output bar_lit, output status_lit, input ready);
   modport sink   (input valid, input level_percent, input average_percent,
                   input bar_lit, input status_lit, output ready);
endinterface

// ===== hdl/lbgm_mul.sv =====
// Shared unsigned multiplier with registered product
module lbgm_mul #(
   parameter int A_W = 15,
   parameter int B_W = 23
) (
   input  logic             clock,
   input  logic             load,
   input  logic [A_W-1:0]   a,
   input  logic [B_W-1:0]   b,
   output logic [A_W+B_W-1:0] product_ff
);

   logic [A_W+B_W-1:0] product_in;

   assign product_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

endmodule

// ===== hdl/lbgm_ctrl.sv =====
// Sequencer stepping one sample through the shared multiplier
module lbgm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lbgm_pkg::stat_type stat,
   output lbgm_pkg::ctrl_type ctl
);

   lbgm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbgm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbgm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lbgm_pkg::ST_DIFF;
            end
         end
         lbgm_pkg::ST_DIFF:   state_in = lbgm_pkg::ST_SCALE;
         lbgm_pkg::ST_SCALE:  state_in = lbgm_pkg::ST_CLAMP;
         lbgm_pkg::ST_CLAMP:  state_in = lbgm_pkg::ST_MAG;
         lbgm_pkg::ST_MAG:    state_in = lbgm_pkg::ST_WEIGHT;
         lbgm_pkg::ST_WEIGHT: state_in = lbgm_pkg::ST_UPDATE;
         lbgm_pkg::ST_UPDATE: state_in = lbgm_pkg::ST_FINISH;
         lbgm_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               state_in = lbgm_pkg::ST_IDLE;
            end
         end
         default: state_in = lbgm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         lbgm_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            ctl.take_sample = req_valid;
         end
         lbgm_pkg::ST_DIFF:   ctl.calc_diff  = 1'b1;
         lbgm_pkg::ST_SCALE:  ctl.mul_level  = 1'b1;
         lbgm_pkg::ST_CLAMP:  ctl.clamp      = 1'b1;
         lbgm_pkg::ST_MAG:    ctl.calc_mag   = 1'b1;
         lbgm_pkg::ST_WEIGHT: ctl.mul_weight = 1'b1;
         lbgm_pkg::ST_UPDATE: ctl.update     = 1'b1;
         lbgm_pkg::ST_FINISH: ctl.commit     = stat.out_free;
         default: ctl = '0;
      endcase
   end

endmodule

// ===== hdl/lbgm_dpath.sv =====
// Level meter datapath: config, scaling, averaging and output register
module lbgm_dpath #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   input  logic                                  csr_wen,
   input  logic [lbgm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lbgm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  lbgm_pkg::ctrl_type                    ctl,
   output lbgm_pkg::stat_type                    stat,
   lbgm_rsp_if.source                            rsp
);

   localparam int DIFF_W  = ((SAMPLE_BITS > lbgm_pkg::OFFSET_W) ?
                             SAMPLE_BITS : lbgm_pkg::OFFSET_W) + 1;
   localparam int MUL_A_W = (SAMPLE_BITS > lbgm_pkg::LEVEL_W) ?
                            SAMPLE_BITS : lbgm_pkg::LEVEL_W;
   localparam int PROD_W  = MUL_A_W + lbgm_pkg::SCALE_W;
   localparam int LW      = lbgm_pkg::LEVEL_W;

   logic [lbgm_pkg::OFFSET_W-1:0] offset_ff;
   logic [lbgm_pkg::SCALE_W-1:0]  scale_ff;
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic [SAMPLE_BITS-1:0]        diff_ff;
   logic                          pos_ff;
   logic [LW-1:0]                 level_ff, level_in;
   logic [LW-1:0]                 mag_ff;
   logic                          down_ff;
   logic [LW-1:0]                 average_ff, average_in;
   logic                          avg_valid_ff;
   logic                          status_off_ff, status_off_in;
   logic                          rsp_valid_ff;
   logic [LW-1:0]                 rsp_level_ff, rsp_average_ff;
   logic [lbgm_pkg::BAR_N-1:0]    rsp_bar_ff, bar_in;
   logic                          rsp_status_ff;

   logic [DIFF_W-1:0]              diff_full;
   logic [MUL_A_W-1:0]             mul_a;
   logic [lbgm_pkg::SCALE_W-1:0]   mul_b;
   logic [PROD_W-1:0]              product;
   logic [PROD_W-9:0]              scaled;
   logic [PROD_W-1:0]              rounded;
   logic [LW-1:0]                  corr;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= lbgm_pkg::OFFSET_RESET;
         scale_ff  <= lbgm_pkg::SCALE_RESET;
      end else if (csr_wen) begin
         if (csr_index == lbgm_pkg::CSR_SAMPLE_OFFSET) begin
            offset_ff <= csr_wdata[lbgm_pkg::OFFSET_W-1:0];
         end
         if (csr_index == lbgm_pkg::CSR_SCALE_Q16) begin
            scale_ff <= csr_wdata[lbgm_pkg::SCALE_W-1:0];
         end
      end
   end

   assign diff_full = DIFF_W'(sample_ff) - DIFF_W'(offset_ff);

   // multiplier serves the scaling first, then the average weight
   assign mul_a = ctl.mul_weight ? MUL_A_W'(mag_ff) : MUL_A_W'(diff_ff);
   assign mul_b = ctl.mul_weight ? lbgm_pkg::SCALE_W'(lbgm_pkg::AVG_WEIGHT) : scale_ff;

   lbgm_mul #(
      .A_W (MUL_A_W),
      .B_W (lbgm_pkg::SCALE_W)
   ) u_mul (
      .clock      (clock),
      .load       (ctl.mul_level | ctl.mul_weight),
      .a          (mul_a),
      .b          (mul_b),
      .product_ff (product)
   );

   assign scaled = product[PROD_W-1:8];

   always_comb begin
      if (!pos_ff) begin
         level_in = '0;
      end else if (scaled > (PROD_W-8)'(lbgm_pkg::LEVEL_FULL)) begin
         level_in = lbgm_pkg::LEVEL_FULL;
      end else begin
         level_in = scaled[LW-1:0];
      end
   end

   // correction fits in 15 bits: weighted magnitude stays below 2^29
   assign rounded = product + PROD_W'(lbgm_pkg::ROUND_HALF);
   assign corr    = rounded[LW+15:16];

   always_comb begin
      if (!avg_valid_ff) begin
         average_in = level_ff;
      end else if (down_ff) begin
         average_in = average_ff - corr;
      end else begin
         average_in = average_ff + corr;
      end
   end

   assign status_off_in = (average_ff < lbgm_pkg::BLINK_BELOW) ? !status_off_ff : 1'b0;

   always_comb begin
      for (int i = 0; i < lbgm_pkg::BAR_N; i++) begin
         bar_in[i] = average_ff > lbgm_pkg::BAR_LEVEL[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_sample) begin
         sample_ff <= req_sample;
      end
      if (ctl.calc_diff) begin
         diff_ff <= diff_full[SAMPLE_BITS-1:0];
         pos_ff  <= !diff_full[DIFF_W-1] && (diff_full != '0);
      end
      if (ctl.clamp) begin
         level_ff <= level_in;
      end
      if (ctl.calc_mag) begin
         down_ff <= average_ff >= level_ff;
         mag_ff  <= (average_ff >= level_ff) ? average_ff - level_ff
                                             : level_ff - average_ff;
      end
      if (ctl.commit) begin
         rsp_level_ff   <= level_ff;
         rsp_average_ff <= average_ff;
         rsp_bar_ff     <= bar_in;
         rsp_status_ff  <= !status_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         average_ff    <= '0;
         avg_valid_ff  <= 1'b0;
         status_off_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.update) begin
            average_ff   <= average_in;
            avg_valid_ff <= 1'b1;
         end
         if (ctl.commit) begin
            status_off_ff <= status_off_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.level_percent   = rsp_level_ff;
   assign rsp.average_percent = rsp_average_ff;
   assign rsp.bar_lit         = rsp_bar_ff;
   assign rsp.status_lit      = rsp_status_ff;

endmodule

// ===== hdl/level_bar_graph_meter_unit.sv =====
// Top level of the bar-graph level meter with exponential average
// Each request carries one raw sensor sample and yields one response holding the
// clamped Q7.8 level, the updated average, the five bar segments and the status
// light. Seven sequencer steps follow a sample's accept before the next request
// is taken, because a single multiplier is used twice per sample, once for offset
// scaling and once for the averaging weight.
// The response sits in an output register; if it has not been taken when the
// next one is ready, the sequencer holds in its last step until it is.
// Configuration writes are taken at any time but should only be made while idle.
module level_bar_graph_meter_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   lbgm_req_if.sink                        req,
   lbgm_rsp_if.source                      rsp,
   input  logic                            csr_wen,
   input  logic [lbgm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbgm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lbgm_pkg::ctrl_type ctl;
   lbgm_pkg::stat_type stat;
   logic               ready;

   assign req.ready = ready;

   lbgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   lbgm_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req.sample),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .stat       (stat),
      .rsp        (rsp)
   );

endmodule

// ===== hdl/lbgm_checker.sv =====
// Port-level assertions for the level meter, bound to the top level
module lbgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [14:0] rsp_level_percent,
   input logic [14:0] rsp_average_percent,
   input logic [4:0]  rsp_bar_lit,
   input logic        rsp_status_lit
);

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_average_percent)))
      else $error("stalled response changed");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_percent <= 15'd25600 && rsp_average_percent <= 15'd25600))
      else $error("level or average above full scale");

   // segments fill from the bottom
   a_bar_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_lit == 5'd0 || rsp_bar_lit == 5'd1 || rsp_bar_lit == 5'd3 ||
                     rsp_bar_lit == 5'd7 || rsp_bar_lit == 5'd15 || rsp_bar_lit == 5'd31))
      else $error("bar graph not contiguous");

   a_steady_light: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_average_percent >= 15'd1280) |-> rsp_status_lit)
      else $error("status light off above blink level");

endmodule

bind level_bar_graph_meter_unit lbgm_checker u_lbgm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_level_percent   (rsp.level_percent),
   .rsp_average_percent (rsp.average_percent),
   .rsp_bar_lit         (rsp.bar_lit),
   .rsp_status_lit      (rsp.status_lit)
);
